@@ sv/rtch_pkg.sv @@
`default_nettype none

package rtch_pkg;

  // Number format.
  localparam int FRAC_BITS = 16;
  localparam int UV_BITS = 16;
  localparam int COORD_W = 32;
  localparam int DIST_W = 31;
  localparam int UV_W = UV_BITS + 1;
  localparam int INDEX_W = 16;

  // A floored product is 48 bits wide and a sum of three stays well inside 50 bits.
  localparam int PROD_W = 2 * COORD_W;
  localparam int DOT_W = 50;

  // Smallest distance and determinant magnitude, 1e-6 in fixed point, at least one LSB.
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 500000) / 1000000;
  localparam int EPS_FIX = (EPS_RAW > 0) ? EPS_RAW : 1;
  localparam logic [DIST_W-1:0] T_MAX = {DIST_W{1'b1}};

  // Divider length: one quotient bit per cycle.
  localparam int T_ITERS = DIST_W;
  localparam int ITER_W = $clog2(T_ITERS);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd6;

  // Product groups of the front sequencer: cross products first, then dot products.
  localparam int GRP_W = 4;
  localparam logic [GRP_W-1:0] G_P0 = 4'd0;
  localparam logic [GRP_W-1:0] G_P1 = 4'd1;
  localparam logic [GRP_W-1:0] G_P2 = 4'd2;
  localparam logic [GRP_W-1:0] G_Q0 = 4'd3;
  localparam logic [GRP_W-1:0] G_Q1 = 4'd4;
  localparam logic [GRP_W-1:0] G_Q2 = 4'd5;
  localparam logic [GRP_W-1:0] G_DET = 4'd6;
  localparam logic [GRP_W-1:0] G_UN = 4'd7;
  localparam logic [GRP_W-1:0] G_VN = 4'd8;
  localparam logic [GRP_W-1:0] G_TN = 4'd9;

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_CLASS} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} back_state_t;

  // Ray registers seen by the front.
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
  } ray_t;

  // Distance limit write seen by the back.
  typedef struct packed {
    logic we;
    logic [DIST_W-1:0] value;
  } lim_wr_t;

  // One classified triangle, sign-normalized so that det is not negative.
  typedef struct packed {
    logic cand;
    logic [DOT_W-1:0] det;
    logic [DOT_W-1:0] un;
    logic [DOT_W-1:0] vn;
    logic [DOT_W-1:0] tn;
    logic [INDEX_W-1:0] tri_index;
    logic last_tri;
  } cand_t;

  // Saturating difference of two coordinates.
  function automatic logic signed [COORD_W-1:0] sat_sub(input logic signed [COORD_W-1:0] x,
                                                         input logic signed [COORD_W-1:0] y);
    logic signed [COORD_W:0] d;
    d = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    if (d[COORD_W] != d[COORD_W-1]) begin
      return d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return d[COORD_W-1:0];
  endfunction

  // Saturate a wide sum to a coordinate.
  function automatic logic signed [COORD_W-1:0] sat_dot(input logic signed [DOT_W-1:0] x);
    logic [DOT_W-COORD_W:0] upper;
    upper = x[DOT_W-1:COORD_W-1];
    if ((&upper) || !(|upper)) begin
      return x[COORD_W-1:0];
    end
    return x[DOT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  // Cross product groups take two terms, dot product groups three.
  function automatic logic term_last(input logic [GRP_W-1:0] grp, input logic [1:0] term);
    return (grp < G_DET) ? (term == 2'd1) : (term == 2'd2);
  endfunction

endpackage

`default_nettype wire

@@ sv/rtch_queue.sv @@
`default_nettype none

module rtch_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  rtch_pkg::cand_t     push_data,
  input  wire logic           pop,
  output rtch_pkg::cand_t     pop_data,
  output logic                full,
  output logic                empty
);
  import rtch_pkg::*;

  cand_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ sv/rtch_front.sv @@
`default_nettype none

module rtch_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  rtch_pkg::ray_t                      ray,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_a_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_a_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_a_z,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_b_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_b_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_b_z,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_c_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_c_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0] vert_c_z,
  input  wire logic [rtch_pkg::INDEX_W-1:0]   tri_index,
  input  wire logic                           last_tri,
  output logic                                push,
  output rtch_pkg::cand_t                     push_data,
  input  wire logic                           q_full
);
  import rtch_pkg::*;

  front_state_t state;
  front_state_t state_next;
  logic accept;

  // Edge vectors, origin offset and the two cross products.
  logic signed [COORD_W-1:0] e1 [3];
  logic signed [COORD_W-1:0] e2 [3];
  logic signed [COORD_W-1:0] sv [3];
  logic signed [COORD_W-1:0] dv [3];
  logic signed [COORD_W-1:0] p [3];
  logic signed [COORD_W-1:0] q [3];
  logic signed [DOT_W-1:0] det;
  logic signed [DOT_W-1:0] un;
  logic signed [DOT_W-1:0] vn;
  logic signed [DOT_W-1:0] tn;
  logic [INDEX_W-1:0] idx;
  logic last;

  // Sequencer and multiplier stage.
  logic [GRP_W-1:0] grp;
  logic [1:0] term;
  logic issuing;
  logic signed [COORD_W-1:0] opa;
  logic signed [COORD_W-1:0] opb;
  logic signed [PROD_W-1:0] prod;
  logic tag_valid;
  logic [GRP_W-1:0] tag_grp;
  logic [1:0] tag_term;
  logic signed [DOT_W-1:0] acc;

  logic signed [DOT_W-1:0] fext;
  logic signed [DOT_W-1:0] sum;
  logic tag_neg;
  logic tag_last;

  assign dv[0] = ray.dx;
  assign dv[1] = ray.dy;
  assign dv[2] = ray.dz;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_RUN;
        end
      end
      F_RUN: begin
        if (tag_valid && tag_grp == G_TN && tag_last) begin
          state_next = F_CLASS;
        end
      end
      F_CLASS: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall = (state != F_IDLE);
    accept = (state == F_IDLE) && in_valid;
    push = (state == F_CLASS) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    case (grp)
      G_P0: begin opa = term[0] ? dv[2] : dv[1]; opb = term[0] ? e2[1] : e2[2]; end
      G_P1: begin opa = term[0] ? dv[0] : dv[2]; opb = term[0] ? e2[2] : e2[0]; end
      G_P2: begin opa = term[0] ? dv[1] : dv[0]; opb = term[0] ? e2[0] : e2[1]; end
      G_Q0: begin opa = term[0] ? sv[2] : sv[1]; opb = term[0] ? e1[1] : e1[2]; end
      G_Q1: begin opa = term[0] ? sv[0] : sv[2]; opb = term[0] ? e1[2] : e1[0]; end
      G_Q2: begin opa = term[0] ? sv[1] : sv[0]; opb = term[0] ? e1[0] : e1[1]; end
      G_DET: begin
        case (term)
          2'd0: begin opa = e1[0]; opb = p[0]; end
          2'd1: begin opa = e1[1]; opb = p[1]; end
          default: begin opa = e1[2]; opb = p[2]; end
        endcase
      end
      G_UN: begin
        case (term)
          2'd0: begin opa = sv[0]; opb = p[0]; end
          2'd1: begin opa = sv[1]; opb = p[1]; end
          default: begin opa = sv[2]; opb = p[2]; end
        endcase
      end
      G_VN: begin
        case (term)
          2'd0: begin opa = dv[0]; opb = q[0]; end
          2'd1: begin opa = dv[1]; opb = q[1]; end
          default: begin opa = dv[2]; opb = q[2]; end
        endcase
      end
      G_TN: begin
        case (term)
          2'd0: begin opa = e2[0]; opb = q[0]; end
          2'd1: begin opa = e2[1]; opb = q[1]; end
          default: begin opa = e2[2]; opb = q[2]; end
        endcase
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Floor the registered product and add it into the running group sum.
  always_comb begin
    fext = DOT_W'(signed'(prod[PROD_W-1:FRAC_BITS]));
    tag_neg = (tag_grp < G_DET) && (tag_term == 2'd1);
    tag_last = term_last(tag_grp, tag_term);
    sum = ((tag_term == 2'd0) ? '0 : acc) + (tag_neg ? -fext : fext);
  end

  // Capture, issue and accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      tag_valid <= 1'b0;
    end else begin
      if (accept) begin
        issuing <= 1'b1;
        grp <= G_P0;
        term <= 2'd0;
      end else if (issuing) begin
        if (term_last(grp, term)) begin
          term <= 2'd0;
          grp <= grp + 1'b1;
          if (grp == G_TN) begin
            issuing <= 1'b0;
          end
        end else begin
          term <= term + 1'b1;
        end
      end
      tag_valid <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e1[0] <= sat_sub(vert_b_x, vert_a_x);
      e1[1] <= sat_sub(vert_b_y, vert_a_y);
      e1[2] <= sat_sub(vert_b_z, vert_a_z);
      e2[0] <= sat_sub(vert_c_x, vert_a_x);
      e2[1] <= sat_sub(vert_c_y, vert_a_y);
      e2[2] <= sat_sub(vert_c_z, vert_a_z);
      sv[0] <= sat_sub(ray.ox, vert_a_x);
      sv[1] <= sat_sub(ray.oy, vert_a_y);
      sv[2] <= sat_sub(ray.oz, vert_a_z);
      idx <= tri_index;
      last <= last_tri;
    end
    prod <= opa * opb;
    tag_grp <= grp;
    tag_term <= term;
    if (tag_valid) begin
      acc <= sum;
      if (tag_last) begin
        case (tag_grp)
          G_P0: p[0] <= sat_dot(sum);
          G_P1: p[1] <= sat_dot(sum);
          G_P2: p[2] <= sat_dot(sum);
          G_Q0: q[0] <= sat_dot(sum);
          G_Q1: q[1] <= sat_dot(sum);
          G_Q2: q[2] <= sat_dot(sum);
          G_DET: det <= sum;
          G_UN: un <= sum;
          G_VN: vn <= sum;
          G_TN: tn <= sum;
          default: acc <= sum;
        endcase
      end
    end
  end

  // Classification: normalize the sign of det and test the barycentric range.
  logic neg;
  logic signed [DOT_W-1:0] dn;
  logic signed [DOT_W-1:0] unn;
  logic signed [DOT_W-1:0] vnn;
  logic signed [DOT_W-1:0] tnn;
  logic signed [DOT_W:0] uvsum;

  always_comb begin
    neg = det[DOT_W-1];
    dn = neg ? -det : det;
    unn = neg ? -un : un;
    vnn = neg ? -vn : vn;
    tnn = neg ? -tn : tn;
    uvsum = {unn[DOT_W-1], unn} + {vnn[DOT_W-1], vnn};
    push_data.cand = ($unsigned(dn) >= DOT_W'(EPS_FIX)) && !unn[DOT_W-1] && (unn <= dn)
                     && !vnn[DOT_W-1] && (uvsum <= {1'b0, dn}) && !tnn[DOT_W-1]
                     && (tnn != '0);
    push_data.det = dn;
    push_data.un = unn;
    push_data.vn = vnn;
    push_data.tn = tnn;
    push_data.tri_index = idx;
    push_data.last_tri = last;
  end

endmodule

`default_nettype wire

@@ sv/rtch_back.sv @@
`default_nettype none

module rtch_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  rtch_pkg::lim_wr_t                  lim_wr,
  input  rtch_pkg::cand_t                    q_data,
  input  wire logic                          q_empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               is_new_closest,
  output logic [rtch_pkg::DIST_W-1:0]        closest_distance,
  output logic [rtch_pkg::UV_W-1:0]          closest_u,
  output logic [rtch_pkg::UV_W-1:0]          closest_v,
  output logic [rtch_pkg::INDEX_W-1:0]       closest_index,
  output logic                               found_any,
  output logic                               ray_done
);
  import rtch_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic load_out;
  logic out_free;

  // Item under division.
  logic cand;
  logic [INDEX_W-1:0] idx;
  logic last;
  logic [DOT_W-1:0] den;
  logic [DOT_W-1:0] rem_t;
  logic [DOT_W-1:0] rem_u;
  logic [DOT_W-1:0] rem_v;
  logic [T_ITERS-1:0] tbits;
  logic [T_ITERS-1:0] qt;
  logic [UV_BITS-1:0] qu;
  logic [UV_BITS-1:0] qv;
  logic u_full;
  logic v_full;
  logic sat_t;
  logic [ITER_W-1:0] cnt;

  // Running closest hit and the limit it reloads from.
  logic [DIST_W-1:0] limit;
  logic [DIST_W-1:0] held_distance;
  logic [UV_W-1:0] held_u;
  logic [UV_W-1:0] held_v;
  logic [INDEX_W-1:0] held_index;
  logic any_hit_flag;

  logic [DOT_W-1:0] rt2;
  logic [DOT_W-1:0] ru2;
  logic [DOT_W-1:0] rv2;
  logic [DIST_W-1:0] t_val;
  logic [UV_W-1:0] u_val;
  logic [UV_W-1:0] v_val;
  logic hit;

  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = q_data.cand ? B_DIV : B_DONE;
        end
      end
      B_DIV: begin
        if (cnt == ITER_W'(T_ITERS - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop = (state == B_IDLE) && !q_empty;
    load_out = (state == B_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring step for each of the three quotients.
  always_comb begin
    rt2 = {rem_t[DOT_W-2:0], tbits[T_ITERS-1]};
    ru2 = {rem_u[DOT_W-2:0], 1'b0};
    rv2 = {rem_v[DOT_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cand <= q_data.cand;
      idx <= q_data.tri_index;
      last <= q_data.last_tri;
      den <= q_data.det;
      // t overflows exactly when tn >= det * 2^15.
      sat_t <= ((q_data.tn >> (T_ITERS - FRAC_BITS)) >= q_data.det);
      rem_t <= q_data.tn >> (T_ITERS - FRAC_BITS);
      tbits <= {q_data.tn[T_ITERS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      rem_u <= q_data.un;
      rem_v <= q_data.vn;
      u_full <= (q_data.un == q_data.det);
      v_full <= (q_data.vn == q_data.det);
      cnt <= '0;
    end else if (state == B_DIV) begin
      cnt <= cnt + 1'b1;
      tbits <= tbits << 1;
      if (rt2 >= den) begin
        rem_t <= rt2 - den;
        qt <= {qt[T_ITERS-2:0], 1'b1};
      end else begin
        rem_t <= rt2;
        qt <= {qt[T_ITERS-2:0], 1'b0};
      end
      if (cnt < ITER_W'(UV_BITS)) begin
        if (ru2 >= den) begin
          rem_u <= ru2 - den;
          qu <= {qu[UV_BITS-2:0], 1'b1};
        end else begin
          rem_u <= ru2;
          qu <= {qu[UV_BITS-2:0], 1'b0};
        end
        if (rv2 >= den) begin
          rem_v <= rv2 - den;
          qv <= {qv[UV_BITS-2:0], 1'b1};
        end else begin
          rem_v <= rv2;
          qv <= {qv[UV_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Final distance test against the held hit.
  always_comb begin
    t_val = sat_t ? T_MAX : qt;
    u_val = u_full ? UV_W'(1 << UV_BITS) : {1'b0, qu};
    v_val = v_full ? UV_W'(1 << UV_BITS) : {1'b0, qv};
    hit = cand && (t_val > DIST_W'(EPS_FIX)) && (t_val < held_distance);
  end

  // Held hit, output register and batch reload.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= T_MAX;
      held_distance <= T_MAX;
      held_u <= '0;
      held_v <= '0;
      held_index <= '0;
      any_hit_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (lim_wr.we) begin
        limit <= lim_wr.value;
        if (!any_hit_flag) begin
          held_distance <= lim_wr.value;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
        is_new_closest <= hit;
        closest_distance <= hit ? t_val : held_distance;
        closest_u <= hit ? u_val : held_u;
        closest_v <= hit ? v_val : held_v;
        closest_index <= hit ? idx : held_index;
        found_any <= hit || any_hit_flag;
        ray_done <= last;
        if (last) begin
          held_distance <= limit;
          held_u <= '0;
          held_v <= '0;
          held_index <= '0;
          any_hit_flag <= 1'b0;
        end else if (hit) begin
          held_distance <= t_val;
          held_u <= u_val;
          held_v <= v_val;
          held_index <= idx;
          any_hit_flag <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_new_implies_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new_closest |-> found_any)
    else $error("new closest hit without found flag");

  a_hit_above_eps: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new_closest |-> closest_distance > DIST_W'(EPS_FIX))
    else $error("hit distance not above epsilon");

  a_empty_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found_any |-> closest_u == '0 && closest_v == '0 && closest_index == '0)
    else $error("no hit held but hit fields nonzero");

endmodule

`default_nettype wire

@@ sv/ray_triangle_closest_hit.sv @@
`default_nettype none

// Channel   Direction  Handshake             Payload
// config    in         cfg_we                cfg_index, cfg_data
// triangle  in         in_valid / in_stall   vert_a_x .. vert_c_z, tri_index, last_tri
// result    out        out_valid / out_stall is_new_closest .. ray_done
//
// The front runs all 24 products of one triangle through a single 32x32 multiplier,
// one per cycle, and takes a new triangle only once it has pushed the last one.
// The back runs a restoring divider only for triangles that pass the range test.
// A two-entry queue parts the front from the back, and an output register parts the
// back from out_stall. Reset is synchronous and needs no clearing pass.

module ray_triangle_closest_hit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [rtch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rtch_pkg::COORD_W-1:0]         cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_a_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_a_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_a_z,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_b_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_b_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_b_z,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_c_x,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_c_y,
  input  wire logic signed [rtch_pkg::COORD_W-1:0]  vert_c_z,
  input  wire logic [rtch_pkg::INDEX_W-1:0]         tri_index,
  input  wire logic                                 last_tri,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      is_new_closest,
  output logic [rtch_pkg::DIST_W-1:0]               closest_distance,
  output logic [rtch_pkg::UV_W-1:0]                 closest_u,
  output logic [rtch_pkg::UV_W-1:0]                 closest_v,
  output logic [rtch_pkg::INDEX_W-1:0]              closest_index,
  output logic                                      found_any,
  output logic                                      ray_done
);
  import rtch_pkg::*;

  ray_t ray;
  lim_wr_t lim_wr;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cand_t push_data;
  cand_t pop_data;

  // Ray registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray.ox <= '0;
      ray.oy <= '0;
      ray.oz <= '0;
      ray.dx <= '0;
      ray.dy <= '0;
      ray.dz <= COORD_W'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: ray.ox <= cfg_data;
        CFG_ORIGIN_Y: ray.oy <= cfg_data;
        CFG_ORIGIN_Z: ray.oz <= cfg_data;
        CFG_DIR_X: ray.dx <= cfg_data;
        CFG_DIR_Y: ray.dy <= cfg_data;
        CFG_DIR_Z: ray.dz <= cfg_data;
        default: ray.dz <= ray.dz;
      endcase
    end
  end

  // The distance limit lives in the back next to the held hit.
  assign lim_wr.we = cfg_we && (cfg_index == CFG_LIMIT);
  assign lim_wr.value = cfg_data[DIST_W-1:0];

  rtch_front u_front (
    .clk(clk),
    .rst(rst),
    .ray(ray),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .vert_a_x(vert_a_x),
    .vert_a_y(vert_a_y),
    .vert_a_z(vert_a_z),
    .vert_b_x(vert_b_x),
    .vert_b_y(vert_b_y),
    .vert_b_z(vert_b_z),
    .vert_c_x(vert_c_x),
    .vert_c_y(vert_c_y),
    .vert_c_z(vert_c_z),
    .tri_index(tri_index),
    .last_tri(last_tri),
    .push(push),
    .push_data(push_data),
    .q_full(q_full)
  );

  rtch_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .pop_data(pop_data),
    .full(q_full),
    .empty(q_empty)
  );

  rtch_back u_back (
    .clk(clk),
    .rst(rst),
    .lim_wr(lim_wr),
    .q_data(pop_data),
    .q_empty(q_empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_new_closest(is_new_closest),
    .closest_distance(closest_distance),
    .closest_u(closest_u),
    .closest_v(closest_v),
    .closest_index(closest_index),
    .found_any(found_any),
    .ray_done(ray_done)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rtch_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int ITEMS_PER_PHASE = 262;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    int vert[9];
    logic [INDEX_W-1:0] idx;
    logic last;
  } tri_t;

  typedef struct {
    logic new_closest;
    logic [DIST_W-1:0] t_dist;
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
    logic [INDEX_W-1:0] idx;
    logic found;
    logic done;
  } hit_t;

  // Directed row: when typed is set, the expected beat is given here.
  typedef struct {
    tri_t tri_in;
    logic typed;
    hit_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ORIGIN_X;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] vert_a_x = '0, vert_a_y = '0, vert_a_z = '0;
  logic signed [COORD_W-1:0] vert_b_x = '0, vert_b_y = '0, vert_b_z = '0;
  logic signed [COORD_W-1:0] vert_c_x = '0, vert_c_y = '0, vert_c_z = '0;
  logic [INDEX_W-1:0] tri_index = '0;
  logic last_tri = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_new_closest;
  logic [DIST_W-1:0] closest_distance;
  logic [UV_W-1:0] closest_u;
  logic [UV_W-1:0] closest_v;
  logic [INDEX_W-1:0] closest_index;
  logic found_any;
  logic ray_done;

  ray_triangle_closest_hit i_dut (.*);

  // Model state of the closest-hit search.
  longint ray_org[3];
  longint ray_dir[3];
  logic [DIST_W-1:0] dist_limit;
  logic [DIST_W-1:0] best_dist;
  logic [UV_W-1:0] best_u, best_v;
  logic [INDEX_W-1:0] best_idx;
  logic any_hit;

  hit_t pending_hits[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Overall cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Product floored to the fixed-point grid.
  function automatic longint fixmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic void cross_sat(output longint o[3], input longint a[3], input longint b[3]);
    o[0] = sat32(fixmul(a[1], b[2]) - fixmul(a[2], b[1]));
    o[1] = sat32(fixmul(a[2], b[0]) - fixmul(a[0], b[2]));
    o[2] = sat32(fixmul(a[0], b[1]) - fixmul(a[1], b[0]));
  endfunction

  function automatic longint dot_exact(longint a[3], longint b[3]);
    return fixmul(a[0], b[0]) + fixmul(a[1], b[1]) + fixmul(a[2], b[2]);
  endfunction

  // Floor of n * 2^fb / d, clamped to maxv.
  function automatic logic [63:0] fixdiv(logic [63:0] n, logic [63:0] d, int fb,
                                         logic [63:0] maxv);
    logic [63:0] q, r;
    q = n / d;
    r = n % d;
    if (q > (maxv >> fb)) return maxv;
    for (int i = 0; i < fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (q > maxv) ? maxv : q;
  endfunction

  function automatic void clear_batch();
    best_dist = dist_limit;
    best_u = '0;
    best_v = '0;
    best_idx = '0;
    any_hit = 1'b0;
  endfunction

  // Intersection test and closest-hit update for one triangle.
  function automatic hit_t closest_hit_step(tri_t t);
    longint a[3], e1[3], e2[3], s[3], p[3], q[3];
    longint det, un, vn, tn;
    logic [63:0] t_fix;
    hit_t r;
    r.new_closest = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.vert[i];
      e1[i] = sat32(longint'(t.vert[3 + i]) - a[i]);
      e2[i] = sat32(longint'(t.vert[6 + i]) - a[i]);
      s[i] = sat32(ray_org[i] - a[i]);
    end
    cross_sat(p, ray_dir, e2);
    det = dot_exact(e1, p);
    if ((det < 0 ? -det : det) >= EPS_FIX) begin
      un = dot_exact(s, p);
      cross_sat(q, s, e1);
      vn = dot_exact(ray_dir, q);
      tn = dot_exact(e2, q);
      if (det < 0) begin
        det = -det;
        un = -un;
        vn = -vn;
        tn = -tn;
      end
      if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn > 0) begin
        t_fix = fixdiv(tn, det, FRAC_BITS, 64'h7FFF_FFFF);
        if (t_fix > EPS_FIX && t_fix < best_dist) begin
          r.new_closest = 1'b1;
          best_dist = t_fix[DIST_W-1:0];
          best_u = UV_W'(fixdiv(un, det, UV_BITS, 64'd1 << UV_BITS));
          best_v = UV_W'(fixdiv(vn, det, UV_BITS, 64'd1 << UV_BITS));
          best_idx = t.idx;
          any_hit = 1'b1;
        end
      end
    end
    r.t_dist = best_dist;
    r.u = best_u;
    r.v = best_v;
    r.idx = best_idx;
    r.found = any_hit;
    r.done = t.last;
    if (t.last) clear_batch();
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = longint'(signed'(data));
      CFG_ORIGIN_Y: ray_org[1] = longint'(signed'(data));
      CFG_ORIGIN_Z: ray_org[2] = longint'(signed'(data));
      CFG_DIR_X: ray_dir[0] = longint'(signed'(data));
      CFG_DIR_Y: ray_dir[1] = longint'(signed'(data));
      CFG_DIR_Z: ray_dir[2] = longint'(signed'(data));
      CFG_LIMIT: begin
        dist_limit = data[DIST_W-1:0];
        if (!any_hit) best_dist = dist_limit;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one triangle beat and wait until it is taken.
  task automatic send_tri(tri_t t, logic typed, hit_t want);
    hit_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {vert_a_x, vert_a_y, vert_a_z} <= {t.vert[0], t.vert[1], t.vert[2]};
    {vert_b_x, vert_b_y, vert_b_z} <= {t.vert[3], t.vert[4], t.vert[5]};
    {vert_c_x, vert_c_y, vert_c_z} <= {t.vert[6], t.vert[7], t.vert[8]};
    tri_index <= t.idx;
    last_tri <= t.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = closest_hit_step(t);
    pending_hits.push_back(typed ? want : predicted);
  endtask

  // Wait for every result, then let the block settle before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(40 * ONE)) - 20 * ONE;
    endcase
  endfunction

  // Triangle placed around a point of the ray, so that many of them are hit.
  function automatic tri_t aimed_tri(logic last);
    tri_t t;
    longint along, center;
    int spread;
    along = longint'($urandom_range(20 * ONE)) - 2 * ONE;
    spread = $urandom_range(3) == 0 ? ONE / 4 : 4 * ONE;
    for (int k = 0; k < 3; k++) begin
      center = sat32(ray_org[k] + fixmul(along, ray_dir[k]));
      for (int v = 0; v < 3; v++) begin
        t.vert[3 * v + k] = int'(sat32(center + $urandom_range(2 * spread) - spread));
      end
    end
    t.idx = INDEX_W'($urandom);
    t.last = last;
    return t;
  endfunction

  // Ray and limit for one phase: a fixed extreme ray for style 0, a random ray otherwise.
  task automatic set_ray(int style);
    int lim;
    if (style == 0) begin
      write_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
      write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
      write_reg(CFG_ORIGIN_Z, 32'h7FFF_FFFF);
      write_reg(CFG_DIR_X, 32'h8000_0000);
      write_reg(CFG_DIR_Y, 32'h7FFF_FFFF);
      write_reg(CFG_DIR_Z, 32'h0000_0001);
    end else begin
      write_reg(CFG_ORIGIN_X, $urandom_range(32 * ONE) - 16 * ONE);
      write_reg(CFG_ORIGIN_Y, $urandom_range(32 * ONE) - 16 * ONE);
      write_reg(CFG_ORIGIN_Z, $urandom_range(32 * ONE) - 16 * ONE);
      write_reg(CFG_DIR_X, $urandom_range(4 * ONE) - 2 * ONE);
      write_reg(CFG_DIR_Y, $urandom_range(4 * ONE) - 2 * ONE);
      write_reg(CFG_DIR_Z, $urandom_range(4 * ONE) + 1);
    end
    case (style)
      0: lim = 0;
      1: lim = 32'h7FFF_FFFF;
      2: lim = $urandom_range(12 * ONE);
      default: lim = $urandom;
    endcase
    // Upper bit is outside the limit register and must be dropped.
    write_reg(CFG_LIMIT, lim | ($urandom_range(1) << 31));
  endtask

  // Result side: check each beat, then choose the next stall.
  always @(posedge clk) begin
    hit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_hits.pop_front();
        if (is_new_closest !== want.new_closest || closest_distance !== want.t_dist ||
            closest_u !== want.u || closest_v !== want.v || closest_index !== want.idx ||
            found_any !== want.found || ray_done !== want.done) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display({"Mismatch at cycle %0d: expected new=%0b t=%h u=%h v=%h idx=%h",
                      " any=%0b done=%0b"},
                     cycles, want.new_closest, want.t_dist, want.u, want.v, want.idx,
                     want.found, want.done);
            $display("  actual new=%0b t=%h u=%h v=%h idx=%h any=%0b done=%0b",
                     is_new_closest, closest_distance, closest_u, closest_v, closest_index,
                     found_any, ray_done);
          end
        end
      end
    end
    // Long hold-off when asked for, random stalls otherwise.
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  row_t directed[10];
  hit_t miss_clear;

  initial begin
    tri_t t;
    hit_t none;
    int batch_left;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, ONE};
    dist_limit = T_MAX;
    clear_batch();
    miss_clear = '{1'b0, T_MAX, '0, '0, '0, 1'b0, 1'b0};
    none = miss_clear;

    // Directed triangles against the reset ray along +z.
    directed[0] = '{'{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 16'd0, 1'b0}, 1'b1, miss_clear};
    directed[1] = '{'{'{9{32'h7FFF_FFFF}}, 16'd1, 1'b0}, 1'b1, miss_clear};
    directed[2] = '{'{'{9{32'h8000_0000}}, 16'd2, 1'b1}, 1'b1, miss_clear};
    directed[2].want.done = 1'b1;
    directed[3] = '{'{'{-ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE, -ONE, 3 * ONE, 5 * ONE},
                     16'd7, 1'b0}, 1'b0, none};
    directed[4] = '{'{'{-ONE, -ONE, 8 * ONE, 3 * ONE, -ONE, 8 * ONE, -ONE, 3 * ONE, 8 * ONE},
                     16'd8, 1'b0}, 1'b0, none};
    directed[5] = '{'{'{-ONE, -ONE, 2 * ONE, -ONE, 3 * ONE, 2 * ONE, 3 * ONE, -ONE, 2 * ONE},
                     16'hFFFF, 1'b0}, 1'b0, none};
    directed[6] = '{'{'{-ONE, -ONE, -3 * ONE, 3 * ONE, -ONE, -3 * ONE, -ONE, 3 * ONE,
                     -3 * ONE}, 16'd9, 1'b0}, 1'b0, none};
    directed[7] = '{'{'{2 * ONE, 2 * ONE, ONE, 3 * ONE, 2 * ONE, ONE, 2 * ONE, 3 * ONE, ONE},
                     16'd10, 1'b0}, 1'b0, none};
    directed[8] = '{'{'{-ONE, -ONE, ONE, 0, 0, ONE, -ONE, ONE, ONE}, 16'd11, 1'b1}, 1'b0, none};
    directed[9] = '{'{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000}, 16'hFFFF, 1'b1}, 1'b0, none};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_tri(directed[i].tri_in, directed[i].typed, directed[i].want);
    wait_idle();
    // A write to the index past the last register has no effect.
    write_reg(CFG_UNUSED, $urandom);

    // Random phases, each with its own ray and idling mix.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 69; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 69; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      set_ray(phase == 0 ? 1 : (phase == 3 ? 0 : $urandom_range(1, 3)));
      batch_left = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 40) hold_req <= ~hold_req;
        batch_left--;
        if ($urandom_range(99) < 75) begin
          t = aimed_tri(batch_left == 0);
        end else begin
          foreach (t.vert[k]) t.vert[k] = rand_coord();
          t.idx = INDEX_W'($urandom);
          t.last = (batch_left == 0) || ($urandom_range(19) == 0);
        end
        if (batch_left <= 0) batch_left = $urandom_range(1, 12);
        send_tri(t, 1'b0, none);
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
